FILE: hw/rtl/uri_component_splitter_macros.svh
// Assertion macros for the URI component splitter.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef URI_COMPONENT_SPLITTER_MACROS_SVH
`define URI_COMPONENT_SPLITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uri_component_splitter: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uri_component_splitter: assertion failed");

`endif

FILE: hw/rtl/ucs_pkg.sv
`default_nettype none

package ucs_pkg;

  localparam int unsigned MAX_LENGTH = 4096;
  localparam int unsigned POS_W      = $clog2(MAX_LENGTH + 1);
  localparam int unsigned OUT_W      = 13;
  localparam int unsigned OUT_MAX    = (1 << OUT_W) - 1;
  localparam int unsigned LEN_CAP    = (MAX_LENGTH > OUT_MAX) ? OUT_MAX : MAX_LENGTH;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SLASH1 = 3'd1,
    PH_AUTH   = 3'd2,
    PH_PATH   = 3'd3,
    PH_QUERY  = 3'd4,
    PH_FRAG   = 3'd5
  } phase_t;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t auth_start;
    pos_t auth_end;
    pos_t path_start;
    pos_t path_end;
    pos_t query_start;
    pos_t query_end;
    pos_t frag_start;
  } offs_t;

  typedef struct packed {
    logic [OUT_W-1:0] scheme_end;
    logic [OUT_W-1:0] authority_start;
    logic [OUT_W-1:0] authority_end;
    logic [OUT_W-1:0] path_start;
    logic [OUT_W-1:0] path_end;
    logic [OUT_W-1:0] query_start;
    logic [OUT_W-1:0] query_end;
    logic [OUT_W-1:0] fragment_start;
    logic [OUT_W-1:0] total_length;
    logic             too_long;
  } span_t;

  function automatic logic [OUT_W-1:0] sat_out(input pos_t v);
    logic [OUT_W-1:0] r;
    if (32'(v) > OUT_MAX) begin
      r = OUT_W'(OUT_MAX);
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ucs_char_if.sv
`default_nettype none

interface ucs_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       last;

  modport source(output valid, char_code, has_char, last, input ready);
  modport sink(input valid, char_code, has_char, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ucs_span_if.sv
`default_nettype none

interface ucs_span_if
  import ucs_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] scheme_end;
  logic [OUT_W-1:0] authority_start;
  logic [OUT_W-1:0] authority_end;
  logic [OUT_W-1:0] path_start;
  logic [OUT_W-1:0] path_end;
  logic [OUT_W-1:0] query_start;
  logic [OUT_W-1:0] query_end;
  logic [OUT_W-1:0] fragment_start;
  logic [OUT_W-1:0] total_length;
  logic             too_long;

  modport source(output valid, scheme_end, authority_start, authority_end, path_start,
                 path_end, query_start, query_end, fragment_start, total_length,
                 too_long, input ready);
  modport sink(input valid, scheme_end, authority_start, authority_end, path_start,
               path_end, query_start, query_end, fragment_start, total_length,
               too_long, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ucs_lane.sv
`default_nettype none

module ucs_lane
  import ucs_pkg::*;
(
  input  logic       en,
  input  phase_t     phase,
  input  offs_t      offs,
  input  pos_t       start,
  input  pos_t       pos,
  input  logic [7:0] code,
  output phase_t     phase_next,
  output offs_t      offs_next
);

  logic is_slash;
  logic is_qmark;
  logic is_hash;
  logic to_path;

  assign is_slash = (code == CH_SLASH);
  assign is_qmark = (code == CH_QMARK);
  assign is_hash  = (code == CH_HASH);

  always_comb begin
    phase_next = phase;
    offs_next  = offs;
    to_path    = 1'b0;
    if (en) begin
      case (phase)
        PH_START: begin
          if (is_slash) begin
            phase_next = PH_SLASH1;
          end else begin
            offs_next.path_start = start;
            to_path = 1'b1;
          end
        end
        PH_SLASH1: begin
          if (is_slash) begin
            offs_next.auth_start = start + POS_W'(2);
            phase_next = PH_AUTH;
          end else begin
            offs_next.path_start = start;
            to_path = 1'b1;
          end
        end
        PH_AUTH: begin
          if (is_slash || is_qmark || is_hash) begin
            offs_next.auth_end   = pos;
            offs_next.path_start = pos;
            to_path = 1'b1;
          end
        end
        PH_PATH: begin
          to_path = 1'b1;
        end
        PH_QUERY: begin
          if (is_hash) begin
            offs_next.query_end  = pos;
            offs_next.frag_start = pos + POS_W'(1);
            phase_next = PH_FRAG;
          end
        end
        default: begin
        end
      endcase

      if (to_path) begin
        phase_next = PH_PATH;
        if (is_qmark) begin
          offs_next.path_end    = pos;
          offs_next.query_start = pos + POS_W'(1);
          phase_next = PH_QUERY;
        end else if (is_hash) begin
          offs_next.path_end   = pos;
          offs_next.frag_start = pos + POS_W'(1);
          phase_next = PH_FRAG;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ucs_result.sv
`default_nettype none

module ucs_result
  import ucs_pkg::*;
(
  input  pos_t   len,
  input  logic   colon_seen,
  input  pos_t   colon_offset,
  input  phase_t plain_phase,
  input  offs_t  plain_offs,
  input  phase_t colon_phase,
  input  offs_t  colon_offs,
  input  logic   overflow,
  output span_t  span
);

  phase_t sel_phase;
  offs_t  off;
  pos_t   start;
  pos_t   scheme;

  always_comb begin
    if (colon_seen) begin
      sel_phase = colon_phase;
      off       = colon_offs;
      start     = colon_offset + POS_W'(1);
      scheme    = colon_offset;
    end else begin
      sel_phase = plain_phase;
      off       = plain_offs;
      start     = '0;
      scheme    = '0;
    end

    case (sel_phase)
      PH_START, PH_SLASH1: begin
        off.path_start = start;
        off.path_end   = len;
      end
      PH_AUTH: begin
        off.auth_end   = len;
        off.path_start = len;
        off.path_end   = len;
      end
      PH_PATH: begin
        off.path_end = len;
      end
      PH_QUERY: begin
        off.query_end = len;
      end
      default: begin
      end
    endcase

    if (len == '0) begin
      off    = '0;
      scheme = '0;
    end

    span.scheme_end      = sat_out(scheme);
    span.authority_start = sat_out(off.auth_start);
    span.authority_end   = sat_out(off.auth_end);
    span.path_start      = sat_out(off.path_start);
    span.path_end        = sat_out(off.path_end);
    span.query_start     = sat_out(off.query_start);
    span.query_end       = sat_out(off.query_end);
    span.fragment_start  = sat_out(off.frag_start);
    span.total_length    = sat_out(len);
    span.too_long        = overflow;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/uri_component_splitter.sv
// The transaction that carries last passes the input stage, then its result is registered.
// Throughput: one character per cycle, no gaps between strings, unless the result stalls.
// The parse state update for one character is a single level of comparators and muxes.
// Reset is synchronous and active high; it clears the input stage, the parse state and
// the result valid flag. The parse state also returns to its reset value after each result.
`default_nettype none

module uri_component_splitter
  import ucs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ucs_char_if.sink      char_in,
  ucs_span_if.source    span_out
);

  logic       s1_valid;
  logic [7:0] s1_code;
  logic       s1_has;
  logic       s1_last;
  logic       s1_fire;
  logic       out_free;

  pos_t   char_position;
  logic   colon_seen;
  pos_t   colon_offset;
  phase_t plain_phase;
  offs_t  plain_offs;
  phase_t colon_phase;
  offs_t  colon_offs;
  logic   overflow;

  pos_t   char_position_next;
  logic   colon_seen_next;
  pos_t   colon_offset_next;
  phase_t plain_phase_next;
  offs_t  plain_offs_next;
  phase_t colon_phase_next;
  offs_t  colon_offs_next;
  logic   overflow_next;

  logic  take;
  logic  new_colon;
  span_t span_next;
  span_t span;
  logic  out_valid;

  assign out_free      = !out_valid || span_out.ready;
  assign s1_fire       = s1_valid && (!s1_last || out_free);
  assign char_in.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
    if (char_in.ready && char_in.valid) begin
      s1_code <= char_in.char_code;
      s1_has  <= char_in.has_char;
      s1_last <= char_in.last;
    end
  end

  assign take      = s1_valid && s1_has && (char_position < POS_W'(MAX_LENGTH));
  assign new_colon = take && !colon_seen && (s1_code == CH_COLON);

  assign char_position_next = take ? char_position + POS_W'(1) : char_position;
  assign colon_seen_next    = colon_seen || new_colon;
  assign colon_offset_next  = new_colon ? char_position : colon_offset;
  assign overflow_next      = overflow || (s1_valid && s1_has && !take);

  ucs_lane u_plain_lane (
    .en         (take),
    .phase      (plain_phase),
    .offs       (plain_offs),
    .start      ('0),
    .pos        (char_position),
    .code       (s1_code),
    .phase_next (plain_phase_next),
    .offs_next  (plain_offs_next)
  );

  ucs_lane u_colon_lane (
    .en         (take && colon_seen),
    .phase      (colon_phase),
    .offs       (colon_offs),
    .start      (colon_offset + POS_W'(1)),
    .pos        (char_position),
    .code       (s1_code),
    .phase_next (colon_phase_next),
    .offs_next  (colon_offs_next)
  );

  ucs_result u_result (
    .len          (char_position_next),
    .colon_seen   (colon_seen_next),
    .colon_offset (colon_offset_next),
    .plain_phase  (plain_phase_next),
    .plain_offs   (plain_offs_next),
    .colon_phase  (colon_phase_next),
    .colon_offs   (colon_offs_next),
    .overflow     (overflow_next),
    .span         (span_next)
  );

  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_last)) begin
      char_position <= '0;
      colon_seen    <= 1'b0;
      colon_offset  <= '0;
      plain_phase   <= PH_START;
      plain_offs    <= '0;
      colon_phase   <= PH_START;
      colon_offs    <= '0;
      overflow      <= 1'b0;
    end else if (s1_fire) begin
      char_position <= char_position_next;
      colon_seen    <= colon_seen_next;
      colon_offset  <= colon_offset_next;
      plain_phase   <= plain_phase_next;
      plain_offs    <= plain_offs_next;
      colon_phase   <= colon_phase_next;
      colon_offs    <= colon_offs_next;
      overflow      <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (span_out.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      span <= span_next;
    end
  end

  assign span_out.valid           = out_valid;
  assign span_out.scheme_end      = span.scheme_end;
  assign span_out.authority_start = span.authority_start;
  assign span_out.authority_end   = span.authority_end;
  assign span_out.path_start      = span.path_start;
  assign span_out.path_end        = span.path_end;
  assign span_out.query_start     = span.query_start;
  assign span_out.query_end       = span.query_end;
  assign span_out.fragment_start  = span.fragment_start;
  assign span_out.total_length    = span.total_length;
  assign span_out.too_long        = span.too_long;

endmodule

`default_nettype wire

FILE: hw/rtl/ucs_checker.sv
`default_nettype none
`include "uri_component_splitter_macros.svh"

module ucs_checker
  import ucs_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [OUT_W-1:0] scheme_end,
  input wire logic [OUT_W-1:0] path_start,
  input wire logic [OUT_W-1:0] path_end,
  input wire logic [OUT_W-1:0] total_length,
  input wire logic             too_long
);

  // A stalled result transaction stays offered with the same length.
  `UCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(total_length))

  // An overlong string reports the length cap.
  `UCS_ASSERT_SAME(a_len_cap, out_valid && too_long, total_length == OUT_W'(LEN_CAP))

  // The scheme and the path lie within the received text.
  `UCS_ASSERT_SAME(a_scheme_in, out_valid, scheme_end <= total_length)
  `UCS_ASSERT_SAME(a_path_in, out_valid, path_start <= path_end && path_end <= total_length)

endmodule

bind uri_component_splitter ucs_checker u_ucs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (span_out.valid),
  .out_ready    (span_out.ready),
  .scheme_end   (span_out.scheme_end),
  .path_start   (span_out.path_start),
  .path_end     (span_out.path_end),
  .total_length (span_out.total_length),
  .too_long     (span_out.too_long)
);

`default_nettype wire
